[hw/rtl/mwmf_pkg.sv]
// Shared types and constants for the masked window median filter.
package mwmf_pkg;

    localparam int PIX_W        = 8;
    localparam int ROW_W        = 12;
    localparam int COL_W        = 11;
    localparam int WIDTH_CFG_W  = 12;
    localparam int HEIGHT_CFG_W = 13;
    localparam int RADIUS_CFG_W = 2;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 13;
    localparam int OUT_DATA_W   = 32;

    localparam logic [PIX_W-1:0] NO_DATA = 8'hFF;

    localparam int MAX_RADIUS_DEF = 3;
    localparam int MAX_WIDTH_DEF  = 2048;
    localparam int MAX_HEIGHT     = 4096;

    // Items in flight between acceptance and the queue.
    localparam int PIPE_DEPTH  = 4;
    localparam int QUEUE_DEPTH = 8;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_RADIUS = 2'd2;

    localparam logic [WIDTH_CFG_W-1:0]  WIDTH_RESET  = 12'd640;
    localparam logic [HEIGHT_CFG_W-1:0] HEIGHT_RESET = 13'd480;
    localparam logic [RADIUS_CFG_W-1:0] RADIUS_RESET = 2'd1;

    typedef struct packed {
        logic             has_int;
        logic             has_pass;
        logic [ROW_W-1:0] int_row;
        logic [COL_W-1:0] int_col;
        logic [ROW_W-1:0] pass_row;
        logic [COL_W-1:0] pass_col;
        logic [PIX_W-1:0] pass_val;
    } step_meta_t;

    typedef struct packed {
        step_meta_t       meta;
        logic [PIX_W-1:0] int_val;
    } step_res_t;

endpackage

[hw/rtl/mwmf_front.sv]
// Front part: position tracking, line buffers and the sliding pixel window.
module mwmf_front #(
    parameter int MAX_RADIUS = mwmf_pkg::MAX_RADIUS_DEF,
    parameter int MAX_WIDTH  = mwmf_pkg::MAX_WIDTH_DEF
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      accept,
    input  logic [mwmf_pkg::PIX_W-1:0]                pix,
    input  logic                                      fs,
    input  logic [mwmf_pkg::WIDTH_CFG_W-1:0]          width_cfg,
    input  logic [mwmf_pkg::HEIGHT_CFG_W-1:0]         height_cfg,
    input  logic [mwmf_pkg::RADIUS_CFG_W-1:0]         radius_cfg,
    output logic                                      win_valid,
    output logic [(2*MAX_RADIUS+1)*(2*MAX_RADIUS+1)-1:0][mwmf_pkg::PIX_W-1:0] win_vals,
    output mwmf_pkg::step_meta_t                      win_meta,
    output logic [$clog2(MAX_RADIUS+1)-1:0]           win_rad
);

    localparam int WS  = 2 * MAX_RADIUS + 1;
    localparam int L   = 2 * MAX_RADIUS;
    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int RW  = $clog2(MAX_RADIUS + 1);
    localparam int RMW = (L > 1) ? $clog2(L) : 1;
    localparam int WX  = (CW + 1 > mwmf_pkg::WIDTH_CFG_W) ? CW + 1 : mwmf_pkg::WIDTH_CFG_W;
    localparam int HW  = mwmf_pkg::HEIGHT_CFG_W;

    logic [mwmf_pkg::ROW_W-1:0] row_cnt_reg, row_cnt_next;
    logic [CW-1:0]              col_cnt_reg, col_cnt_next;
    logic [RMW-1:0]             rm_cnt_reg, rm_cnt_next;

    logic [WX-1:0] w_wide;
    logic [CW:0]   w_e;
    logic [HW-1:0] h_e;
    logic [RW-1:0] rad_e;
    logic [3:0]    rad_wide;

    logic [HW-1:0]  r0, r1, r, rn;
    logic [CW:0]    c0, c1, cn;
    logic [CW-1:0]  c;
    logic [RMW-1:0] rm0, rm1, rm, rmn;
    mwmf_pkg::step_meta_t meta;

    logic                       s1_valid_reg;
    logic [mwmf_pkg::PIX_W-1:0] s1_pix_reg;
    logic [RMW-1:0]             s1_rm_reg;
    mwmf_pkg::step_meta_t       s1_meta_reg;
    logic [RW-1:0]              s1_rad_reg;
    logic [mwmf_pkg::PIX_W-1:0] rd_reg [L];

    logic [WS-1:0][WS-1:0][mwmf_pkg::PIX_W-1:0] win_reg;
    logic [WS-1:0][mwmf_pkg::PIX_W-1:0]         col;
    logic                                       win_valid_reg;
    mwmf_pkg::step_meta_t                       win_meta_reg;
    logic [RW-1:0]                              win_rad_reg;

    always_comb
    begin
        w_wide = WX'(width_cfg);
        if (w_wide == '0)
            w_e = (CW+1)'(1);
        else if (w_wide > WX'(MAX_WIDTH))
            w_e = (CW+1)'(MAX_WIDTH);
        else
            w_e = (CW+1)'(w_wide);
        if (height_cfg == '0)
            h_e = HW'(1);
        else if (height_cfg > HW'(mwmf_pkg::MAX_HEIGHT))
            h_e = HW'(mwmf_pkg::MAX_HEIGHT);
        else
            h_e = height_cfg;
        rad_wide = 4'(radius_cfg);
        rad_e = (rad_wide > 4'(MAX_RADIUS)) ? RW'(MAX_RADIUS) : RW'(rad_wide);
    end

    // Position of the arriving pixel, with frame start and size changes folded in.
    always_comb
    begin
        r0  = fs ? '0 : HW'(row_cnt_reg);
        c0  = fs ? '0 : (CW+1)'(col_cnt_reg);
        rm0 = fs ? '0 : rm_cnt_reg;
        if (c0 >= w_e)
        begin
            c1  = '0;
            r1  = r0 + HW'(1);
            rm1 = (rm0 == RMW'(L - 1)) ? '0 : rm0 + RMW'(1);
        end
        else
        begin
            c1  = c0;
            r1  = r0;
            rm1 = rm0;
        end
        if (r1 >= h_e)
        begin
            r  = '0;
            rm = '0;
        end
        else
        begin
            r  = r1;
            rm = rm1;
        end
        c = c1[CW-1:0];

        meta.has_int  = (r >= HW'({rad_e, 1'b0})) && (c1 >= (CW+1)'({rad_e, 1'b0}));
        meta.has_pass = (r < HW'(rad_e)) || (c1 < (CW+1)'(rad_e))
                     || ((r + HW'(rad_e)) >= h_e) || ((c1 + (CW+1)'(rad_e)) >= w_e);
        meta.int_row  = mwmf_pkg::ROW_W'(r - HW'(rad_e));
        meta.int_col  = mwmf_pkg::COL_W'(c1 - (CW+1)'(rad_e));
        meta.pass_row = mwmf_pkg::ROW_W'(r);
        meta.pass_col = mwmf_pkg::COL_W'(c1);
        meta.pass_val = pix;

        cn  = c1 + (CW+1)'(1);
        rn  = r;
        rmn = rm;
        if (cn >= w_e)
        begin
            cn  = '0;
            rn  = r + HW'(1);
            rmn = (rm == RMW'(L - 1)) ? '0 : rm + RMW'(1);
            if (rn >= h_e)
            begin
                rn  = '0;
                rmn = '0;
            end
        end
        row_cnt_next = mwmf_pkg::ROW_W'(rn);
        col_cnt_next = cn[CW-1:0];
        rm_cnt_next  = rmn;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_cnt_reg  <= '0;
            col_cnt_reg  <= '0;
            rm_cnt_reg   <= '0;
            s1_valid_reg <= 1'b0;
            win_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                row_cnt_reg <= row_cnt_next;
                col_cnt_reg <= col_cnt_next;
                rm_cnt_reg  <= rm_cnt_next;
            end
            s1_valid_reg  <= accept;
            win_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pix_reg  <= pix;
            s1_rm_reg   <= rm;
            s1_meta_reg <= meta;
            s1_rad_reg  <= rad_e;
        end
    end

    // One buffer per stored row; the row that is about to be overwritten is read first.
    for (genvar g = 0; g < L; g++)
    begin : g_line
        logic [mwmf_pkg::PIX_W-1:0] line_mem [MAX_WIDTH];
        always_ff @(posedge clk)
        begin
            if (accept)
            begin
                rd_reg[g] <= line_mem[c];
                if (rm == RMW'(g))
                    line_mem[c] <= pix;
            end
        end
    end

    always_comb
    begin
        int s;
        for (int y = 0; y < L; y++)
        begin
            s = int'(s1_rm_reg) + y;
            if (s >= L)
                s = s - L;
            col[y] = rd_reg[RMW'(s)];
        end
        col[WS-1] = s1_pix_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            for (int y = 0; y < WS; y++)
            begin
                for (int x = 0; x < WS - 1; x++)
                    win_reg[y][x] <= win_reg[y][x+1];
                win_reg[y][WS-1] <= col[y];
            end
            win_meta_reg <= s1_meta_reg;
            win_rad_reg  <= s1_rad_reg;
        end
    end

    assign win_valid = win_valid_reg;
    assign win_vals  = win_reg;
    assign win_meta  = win_meta_reg;
    assign win_rad   = win_rad_reg;

endmodule

[hw/rtl/mwmf_median.sv]
// Masked lower median of the window by pairwise ranking, registered in stages m2 and m3.
module mwmf_median #(
    parameter int MAX_RADIUS = mwmf_pkg::MAX_RADIUS_DEF
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      win_valid,
    input  logic [(2*MAX_RADIUS+1)*(2*MAX_RADIUS+1)-1:0][mwmf_pkg::PIX_W-1:0] win_vals,
    input  mwmf_pkg::step_meta_t                      win_meta,
    input  logic [$clog2(MAX_RADIUS+1)-1:0]           win_rad,
    output logic                                      res_valid,
    output mwmf_pkg::step_res_t                       res
);

    localparam int WS  = 2 * MAX_RADIUS + 1;
    localparam int N   = WS * WS;
    localparam int RW  = $clog2(MAX_RADIUS + 1);
    localparam int NW  = $clog2(N);
    localparam int NCW = $clog2(N + 1);
    localparam int IW  = $clog2(WS);

    logic [N-1:0]              ok;
    logic [N-1:0][N-1:0]       lt;
    logic [IW:0]               lo;
    logic [IW-1:0]             ctr;
    logic [mwmf_pkg::PIX_W-1:0] ctr_val;

    logic                                 m2_valid_reg;
    logic [N-1:0][mwmf_pkg::PIX_W-1:0]    m2_vals_reg;
    logic [N-1:0]                         m2_ok_reg;
    logic [N-1:0][N-1:0]                  m2_lt_reg;
    logic                                 m2_ctr_nd_reg;
    mwmf_pkg::step_meta_t                 m2_meta_reg;

    logic [N-1:0][NW-1:0]                 rank;
    logic [NCW-1:0]                       n;
    logic                                 m3_valid_reg;
    logic [N-1:0][mwmf_pkg::PIX_W-1:0]    m3_vals_reg;
    logic [N-1:0]                         m3_ok_reg;
    logic [N-1:0][NW-1:0]                 m3_rank_reg;
    logic [NCW-1:0]                       m3_n_reg;
    logic                                 m3_ctr_nd_reg;
    mwmf_pkg::step_meta_t                 m3_meta_reg;

    logic [NW-1:0]              target;
    logic [mwmf_pkg::PIX_W-1:0] pick;

    // Entries outside the active radius and no-data entries take no part.
    always_comb
    begin
        lo  = (IW+1)'(WS - 1) - (IW+1)'({win_rad, 1'b0});
        ctr = IW'(WS - 1) - IW'(win_rad);
        ctr_val = '0;
        for (int d = 0; d < WS; d++)
            if (ctr == IW'(d))
                ctr_val = win_vals[d*WS + d];
        for (int i = 0; i < N; i++)
            ok[i] = ((IW+1)'(i / WS) >= lo) && ((IW+1)'(i % WS) >= lo)
                 && (win_vals[i] != mwmf_pkg::NO_DATA);
        // Equal values are ordered by position so that every rank is unique.
        for (int i = 0; i < N; i++)
            for (int j = 0; j < N; j++)
                lt[i][j] = ok[j] && ((win_vals[j] < win_vals[i])
                        || ((win_vals[j] == win_vals[i]) && (j < i)));
    end

    always_comb
    begin
        for (int i = 0; i < N; i++)
        begin
            rank[i] = '0;
            for (int j = 0; j < N; j++)
                rank[i] = rank[i] + NW'(m2_lt_reg[i][j]);
        end
        n = '0;
        for (int i = 0; i < N; i++)
            n = n + NCW'(m2_ok_reg[i]);
    end

    always_comb
    begin
        target = NW'((m3_n_reg - NCW'(1)) >> 1);
        pick = '0;
        for (int i = 0; i < N; i++)
            if (m3_ok_reg[i] && (m3_rank_reg[i] == target))
                pick = pick | m3_vals_reg[i];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m2_valid_reg <= 1'b0;
            m3_valid_reg <= 1'b0;
        end
        else
        begin
            m2_valid_reg <= win_valid;
            m3_valid_reg <= m2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (win_valid)
        begin
            m2_vals_reg   <= win_vals;
            m2_ok_reg     <= ok;
            m2_lt_reg     <= lt;
            m2_ctr_nd_reg <= (ctr_val == mwmf_pkg::NO_DATA);
            m2_meta_reg   <= win_meta;
        end
        if (m2_valid_reg)
        begin
            m3_vals_reg   <= m2_vals_reg;
            m3_ok_reg     <= m2_ok_reg;
            m3_rank_reg   <= rank;
            m3_n_reg      <= n;
            m3_ctr_nd_reg <= m2_ctr_nd_reg;
            m3_meta_reg   <= m2_meta_reg;
        end
    end

    assign res_valid    = m3_valid_reg;
    assign res.meta     = m3_meta_reg;
    assign res.int_val  = (m3_ctr_nd_reg || (m3_n_reg == '0)) ? mwmf_pkg::NO_DATA : pick;

endmodule

[hw/rtl/mwmf_queue.sv]
// Short queue of finished steps between the filter pipeline and the output side.
module mwmf_queue (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        push,
    input  mwmf_pkg::step_res_t                         push_data,
    input  logic                                        pop,
    output mwmf_pkg::step_res_t                         head,
    output logic                                        empty,
    output logic [$clog2(mwmf_pkg::QUEUE_DEPTH+1)-1:0]  count
);

    localparam int QD = mwmf_pkg::QUEUE_DEPTH;
    localparam int PW = $clog2(QD);
    localparam int CNW = $clog2(QD + 1);

    mwmf_pkg::step_res_t store [QD];
    logic [PW-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CNW-1:0] count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + PW'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + PW'(1);
            if (push && !pop)
                count_reg <= count_reg + CNW'(1);
            else if (pop && !push)
                count_reg <= count_reg - CNW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            store[wr_ptr_reg] <= push_data;
    end

    assign head  = store[rd_ptr_reg];
    assign empty = (count_reg == '0);
    assign count = count_reg;

endmodule

[hw/rtl/mwmf_back.sv]
// Back part: turns each queued step into one or two output requests.
module mwmf_back (
    input  logic                                clk,
    input  logic                                rst_n,
    input  mwmf_pkg::step_res_t                 head,
    input  logic                                empty,
    output logic                                pop,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [mwmf_pkg::OUT_DATA_W-1:0]     m_tdata,
    output logic                                m_tlast
);

    logic second_reg;
    logic show_int;
    logic [mwmf_pkg::ROW_W-1:0] row;
    logic [mwmf_pkg::COL_W-1:0] col;
    logic [mwmf_pkg::PIX_W-1:0] val;

    // The delayed interior pixel goes out before the pass-through of the new one.
    always_comb
    begin
        show_int = head.meta.has_int && !second_reg;
        if (show_int)
        begin
            row = head.meta.int_row;
            col = head.meta.int_col;
            val = head.int_val;
        end
        else
        begin
            row = head.meta.pass_row;
            col = head.meta.pass_col;
            val = head.meta.pass_val;
        end
    end

    assign m_tvalid = !empty;
    assign m_tlast  = !(show_int && head.meta.has_pass);
    assign m_tdata  = {1'b0, val, col, row};
    assign pop      = m_tvalid && m_tready && m_tlast;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            second_reg <= 1'b0;
        else if (m_tvalid && m_tready)
            second_reg <= !m_tlast;
    end

endmodule

[hw/rtl/masked_window_median_filter_core.sv]
// An interior result follows the pixel that completes its window, an edge pass-through its
// own pixel, via the input, window, m2, m3 and queue registers; output stalls delay it further.
// Throughput: one pixel per cycle while the output side takes every request; a pixel
// that causes two results holds the output until both have gone out.
// Reset clears position, queue and pipeline control; line buffers and window are not
// cleared, and configuration returns to 640 x 480 with radius 1.
module masked_window_median_filter_core #(
    parameter int MAX_RADIUS = mwmf_pkg::MAX_RADIUS_DEF,
    parameter int MAX_WIDTH  = mwmf_pkg::MAX_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [mwmf_pkg::PIX_W-1:0]          s_tdata,   // [7:0] pixel_value
    input  logic                                s_tuser,   // [0] frame_start
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [mwmf_pkg::OUT_DATA_W-1:0]     m_tdata,   // [11:0] out_row, [22:12] out_col,
                                                           // [30:23] out_value, [31] zero
    output logic                                m_tlast,   // last_of_step
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [mwmf_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mwmf_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int RW  = $clog2(MAX_RADIUS + 1);
    localparam int N   = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1);
    localparam int CNW = $clog2(mwmf_pkg::QUEUE_DEPTH + 1);
    localparam int FW  = $clog2(mwmf_pkg::PIPE_DEPTH + 1);
    localparam int SW  = (CNW > FW) ? CNW + 1 : FW + 1;

    logic [mwmf_pkg::WIDTH_CFG_W-1:0]  width_reg;
    logic [mwmf_pkg::HEIGHT_CFG_W-1:0] height_reg;
    logic [mwmf_pkg::RADIUS_CFG_W-1:0] radius_reg;
    logic [FW-1:0]                     flight_reg;

    logic                              accept;
    logic                              win_valid;
    logic [N-1:0][mwmf_pkg::PIX_W-1:0] win_vals;
    mwmf_pkg::step_meta_t              win_meta;
    logic [RW-1:0]                     win_rad;
    logic                              res_valid;
    mwmf_pkg::step_res_t               res;
    mwmf_pkg::step_res_t               head;
    logic                              empty;
    logic                              pop;
    logic [CNW-1:0]                    q_count;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= mwmf_pkg::WIDTH_RESET;
            height_reg <= mwmf_pkg::HEIGHT_RESET;
            radius_reg <= mwmf_pkg::RADIUS_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                mwmf_pkg::REG_IMAGE_WIDTH:
                    width_reg <= cfg_data[mwmf_pkg::WIDTH_CFG_W-1:0];
                mwmf_pkg::REG_IMAGE_HEIGHT:
                    height_reg <= cfg_data[mwmf_pkg::HEIGHT_CFG_W-1:0];
                mwmf_pkg::REG_WINDOW_RADIUS:
                    radius_reg <= cfg_data[mwmf_pkg::RADIUS_CFG_W-1:0];
                default:
                    ;
            endcase
        end
    end

    // The pipeline never stalls, so a request is taken only if the queue has room
    // for every step still travelling through it.
    assign s_tready = (SW'(q_count) + SW'(flight_reg)) < SW'(mwmf_pkg::QUEUE_DEPTH);
    assign accept   = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            flight_reg <= '0;
        else if (accept && !res_valid)
            flight_reg <= flight_reg + FW'(1);
        else if (res_valid && !accept)
            flight_reg <= flight_reg - FW'(1);
    end

    mwmf_front #(
        .MAX_RADIUS (MAX_RADIUS),
        .MAX_WIDTH  (MAX_WIDTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .pix        (s_tdata),
        .fs         (s_tuser),
        .width_cfg  (width_reg),
        .height_cfg (height_reg),
        .radius_cfg (radius_reg),
        .win_valid  (win_valid),
        .win_vals   (win_vals),
        .win_meta   (win_meta),
        .win_rad    (win_rad)
    );

    mwmf_median #(
        .MAX_RADIUS (MAX_RADIUS)
    ) u_median (
        .clk        (clk),
        .rst_n      (rst_n),
        .win_valid  (win_valid),
        .win_vals   (win_vals),
        .win_meta   (win_meta),
        .win_rad    (win_rad),
        .res_valid  (res_valid),
        .res        (res)
    );

    mwmf_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (res_valid && (res.meta.has_int || res.meta.has_pass)),
        .push_data  (res),
        .pop        (pop),
        .head       (head),
        .empty      (empty),
        .count      (q_count)
    );

    mwmf_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .empty      (empty),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule

[hw/rtl/mwmf_checker.sv]
// Port-level checks for the filter core, bound to the top level.
module mwmf_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                s_tvalid,
    input logic                                s_tready,
    input logic [mwmf_pkg::PIX_W-1:0]          s_tdata,
    input logic                                s_tuser,
    input logic                                m_tvalid,
    input logic                                m_tready,
    input logic [mwmf_pkg::OUT_DATA_W-1:0]     m_tdata,
    input logic                                m_tlast,
    input logic                                cfg_valid,
    input logic                                cfg_ready,
    input logic [mwmf_pkg::CFG_IDX_W-1:0]      cfg_index,
    input logic [mwmf_pkg::CFG_DATA_W-1:0]     cfg_data
);

    // A stalled output request keeps its contents.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output request changed while stalled");

    // The second result of a step is always ready right after the first.
    a_pair_follows: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid)
        else $error("second result of a step missing");

    // The padding bit above the value is never set.
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !m_tdata[mwmf_pkg::OUT_DATA_W-1])
        else $error("output padding bit set");

    // Configuration writes are always taken.
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration request refused");

endmodule

bind masked_window_median_filter_core mwmf_checker u_chk (.*);
